[sv/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg
// shared sizes, codes and types of the lru block buffer cache
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int REF_BITS  = 8;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = SLOT_W + 1;

  localparam logic [CNT_W-1:0]    SLOT_CNT  = CNT_W'(NUM_SLOTS);
  localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [REF_BITS-1:0] REF_MAX   = '1;

  // field widths of the transactions
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int ISLOT_W  = 5;
  localparam int REFOUT_W = 8;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic                valid;
    logic [REF_BITS-1:0] count;
    logic [DEV_W-1:0]    dev;
    logic [BLK_W-1:0]    blk;
  } slot_entry_t;

  typedef struct packed {
    logic                hit_found;
    logic [SLOT_W-1:0]   hit_slot;
    logic [REF_BITS-1:0] hit_count;
    logic                hit_valid;
    logic                free_found;
    logic [SLOT_W-1:0]   free_slot;
  } scan_res_t;

endpackage

[sv/lbc_scan.sv]
// ----------------------------------------------------------------------------
// lbc_scan
// tracks first tag match and last free slot over a scan in recency order
// ----------------------------------------------------------------------------
module lbc_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        elem_valid,
  input  logic [lbc_pkg::SLOT_W-1:0]  elem_slot,
  input  lbc_pkg::slot_entry_t        elem_entry,
  input  logic [lbc_pkg::DEV_W-1:0]   key_dev,
  input  logic [lbc_pkg::BLK_W-1:0]   key_blk,
  output lbc_pkg::scan_res_t          result
);
  import lbc_pkg::*;

  scan_res_t res_r;
  logic      match;

  assign match  = (elem_entry.dev == key_dev) && (elem_entry.blk == key_blk);
  assign result = res_r;

  // elements arrive from mru to lru: keep the first match, the last free one
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      res_r <= '0;
    end else if (elem_valid) begin
      if (match && !res_r.hit_found) begin
        res_r.hit_found <= 1'b1;
        res_r.hit_slot  <= elem_slot;
        res_r.hit_count <= elem_entry.count;
        res_r.hit_valid <= elem_entry.valid;
      end
      if (elem_entry.count == '0) begin
        res_r.free_found <= 1'b1;
        res_r.free_slot  <= elem_slot;
      end
    end
  end

endmodule

[sv/lru_block_buffer_cache.sv]
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// buffer cache slot manager with tag match, reference counts and lru order
// ----------------------------------------------------------------------------
// acquire: from accept to result, one pass over the recency memory feeding
//   the slot memory, one read per cycle
// release: a slot read and check, plus a walk when the count drops to zero
//   (move to front walks the recency memory one entry per cycle)
// one transaction in flight: the next can be accepted in the same cycle that
//   the result goes valid; reset runs a clearing pass over all slots, in_tready low
module lru_block_buffer_cache (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // device[7:0], block_number[39:8], slot[44:40]
  input  logic [0:0]  in_tuser,   // opcode[0]
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // result_slot[4:0], hit[5], needs_read[6],
                                  // refs_after[14:7], status[16:15]
);
  import lbc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_REL_RD, S_REL_CHK, S_MOVE, S_OUT
  } state_t;

  state_t state_r;

  // memories: slot entries and recency order (position 0 is mru)
  slot_entry_t       slot_mem [NUM_SLOTS];
  logic [SLOT_W-1:0] order_mem [NUM_SLOTS];

  slot_entry_t       slot_rdata_r;
  logic [SLOT_W-1:0] ord_rdata_r;

  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  slot_entry_t       slot_wdata;
  logic [SLOT_W-1:0] slot_raddr;
  logic              order_we;
  logic [SLOT_W-1:0] order_waddr;
  logic [SLOT_W-1:0] order_wdata;
  logic [SLOT_W-1:0] order_raddr;

  // request
  logic [DEV_W-1:0]    req_dev_r;
  logic [BLK_W-1:0]    req_blk_r;
  logic [ISLOT_W-1:0]  req_slot_r;

  // clearing pass
  logic [SLOT_W-1:0]   clr_idx_r;

  // scan pipeline: issue order read, then slot read, then compare
  logic [CNT_W-1:0]    scan_issue_r;
  logic                p1_valid_r;
  logic                p1_last_r;
  logic                p2_valid_r;
  logic                p2_last_r;
  logic [SLOT_W-1:0]   p2_slot_r;
  logic                scan_clear;
  scan_res_t           scan_res;

  // move to front walk
  logic [CNT_W-1:0]    mv_issue_r;
  logic                mv_dv_r;
  logic [SLOT_W-1:0]   mv_wpos_r;
  logic [SLOT_W-1:0]   mv_carry_r;

  // staged result and output register
  logic [ISLOT_W-1:0]  res_slot_r;
  logic                res_hit_r;
  logic                res_rd_r;
  logic [REFOUT_W-1:0] res_refs_r;
  status_t             res_status_r;
  logic                out_tvalid_r;
  logic [23:0]         out_tdata_r;

  logic                hit_ovf;
  logic                rel_in_range;
  logic                rel_ok;
  logic [SLOT_W-1:0]   rel_idx;
  logic [REF_BITS-1:0] rel_count_dec;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign scan_clear    = (state_r == S_IDLE) && in_tvalid;
  assign hit_ovf       = (scan_res.hit_count == REF_MAX);
  assign rel_idx       = SLOT_W'(req_slot_r);
  assign rel_in_range  = (32'(req_slot_r) < 32'(NUM_SLOTS));
  assign rel_ok        = rel_in_range && (slot_rdata_r.count != '0);
  assign rel_count_dec = slot_rdata_r.count - REF_BITS'(1);

  lbc_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (scan_clear),
    .elem_valid (p2_valid_r),
    .elem_slot  (p2_slot_r),
    .elem_entry (slot_rdata_r),
    .key_dev    (req_dev_r),
    .key_blk    (req_blk_r),
    .result     (scan_res)
  );

  // memory port steering by state
  always_comb begin
    slot_we     = 1'b0;
    slot_waddr  = '0;
    slot_wdata  = '0;
    slot_raddr  = '0;
    order_we    = 1'b0;
    order_waddr = '0;
    order_wdata = '0;
    order_raddr = '0;
    case (state_r)
      S_CLEAR: begin
        // tags, counts and valid marks to zero; position i holds slot N-1-i
        slot_we     = 1'b1;
        slot_waddr  = clr_idx_r;
        order_we    = 1'b1;
        order_waddr = clr_idx_r;
        order_wdata = SLOT_LAST - clr_idx_r;
      end
      S_SCAN: begin
        order_raddr = scan_issue_r[SLOT_W-1:0];
        slot_raddr  = ord_rdata_r;
      end
      S_DECIDE: begin
        if (scan_res.hit_found) begin
          // hit: bump the count and mark valid, unless the count is saturated
          if (!hit_ovf) begin
            slot_we          = 1'b1;
            slot_waddr       = scan_res.hit_slot;
            slot_wdata.valid = 1'b1;
            slot_wdata.count = scan_res.hit_count + REF_BITS'(1);
            slot_wdata.dev   = req_dev_r;
            slot_wdata.blk   = req_blk_r;
          end
        end else if (scan_res.free_found) begin
          // miss: retag the lru free slot, one reference, filled by caller
          slot_we          = 1'b1;
          slot_waddr       = scan_res.free_slot;
          slot_wdata.valid = 1'b1;
          slot_wdata.count = REF_BITS'(1);
          slot_wdata.dev   = req_dev_r;
          slot_wdata.blk   = req_blk_r;
        end
      end
      S_REL_RD: begin
        slot_raddr = rel_idx;
      end
      S_REL_CHK: begin
        if (rel_ok) begin
          slot_we          = 1'b1;
          slot_waddr       = rel_idx;
          slot_wdata       = slot_rdata_r;
          slot_wdata.count = rel_count_dec;
        end
      end
      S_MOVE: begin
        // read the next position while the previous one is rewritten
        order_raddr = mv_issue_r[SLOT_W-1:0];
        if (mv_dv_r) begin
          order_we    = 1'b1;
          order_waddr = mv_wpos_r;
          order_wdata = mv_carry_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    ord_rdata_r <= order_mem[order_raddr];
  end

  // control state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      scan_issue_r <= '0;
      p1_valid_r   <= 1'b0;
      p2_valid_r   <= 1'b0;
      mv_issue_r   <= '0;
      mv_dv_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      p1_valid_r <= (state_r == S_SCAN) && (scan_issue_r < SLOT_CNT);
      p2_valid_r <= p1_valid_r;
      p2_last_r  <= p1_last_r;
      p2_slot_r  <= ord_rdata_r;

      // the result stage reloads on its own when it hands over
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + SLOT_W'(1);
          if (clr_idx_r == SLOT_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            req_dev_r    <= in_tdata[7:0];
            req_blk_r    <= in_tdata[39:8];
            req_slot_r   <= in_tdata[44:40];
            scan_issue_r <= '0;
            if (in_tuser[0] == OP_RELEASE) begin
              state_r <= S_REL_RD;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_issue_r < SLOT_CNT) begin
            p1_last_r    <= (scan_issue_r == SLOT_CNT - CNT_W'(1));
            scan_issue_r <= scan_issue_r + CNT_W'(1);
          end
          // last element enters the scan unit at this edge
          if (p2_valid_r && p2_last_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (scan_res.hit_found) begin
            res_slot_r <= ISLOT_W'(scan_res.hit_slot);
            res_hit_r  <= 1'b1;
            if (hit_ovf) begin
              res_rd_r     <= 1'b0;
              res_refs_r   <= REFOUT_W'(scan_res.hit_count);
              res_status_r <= ST_OVERFLOW;
            end else begin
              res_rd_r     <= !scan_res.hit_valid;
              res_refs_r   <= REFOUT_W'(scan_res.hit_count + REF_BITS'(1));
              res_status_r <= ST_OK;
            end
          end else if (scan_res.free_found) begin
            res_slot_r   <= ISLOT_W'(scan_res.free_slot);
            res_hit_r    <= 1'b0;
            res_rd_r     <= 1'b1;
            res_refs_r   <= REFOUT_W'(1);
            res_status_r <= ST_OK;
          end else begin
            res_slot_r   <= '0;
            res_hit_r    <= 1'b0;
            res_rd_r     <= 1'b0;
            res_refs_r   <= '0;
            res_status_r <= ST_NO_FREE;
          end
          state_r <= S_OUT;
        end
        S_REL_RD: begin
          state_r <= S_REL_CHK;
        end
        S_REL_CHK: begin
          res_slot_r <= req_slot_r;
          res_hit_r  <= 1'b0;
          res_rd_r   <= 1'b0;
          if (rel_ok) begin
            res_refs_r   <= REFOUT_W'(rel_count_dec);
            res_status_r <= ST_OK;
          end else begin
            res_refs_r   <= '0;
            res_status_r <= ST_UNDERFLOW;
          end
          if (rel_ok && (rel_count_dec == '0)) begin
            state_r    <= S_MOVE;
            mv_issue_r <= '0;
            mv_dv_r    <= 1'b0;
            mv_carry_r <= rel_idx;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_MOVE: begin
          // shift entries down by one until the released slot is reached
          mv_dv_r   <= (mv_issue_r < SLOT_CNT) &&
                       !(mv_dv_r && (ord_rdata_r == rel_idx));
          mv_wpos_r <= mv_issue_r[SLOT_W-1:0];
          if (mv_issue_r < SLOT_CNT) begin
            mv_issue_r <= mv_issue_r + CNT_W'(1);
          end
          if (mv_dv_r) begin
            mv_carry_r <= ord_rdata_r;
            if (ord_rdata_r == rel_idx) begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {7'd0, res_status_r, res_refs_r, res_rd_r,
                             res_hit_r, res_slot_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // a new result only comes out of the result stage
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result appeared outside the result stage");

  // scan pipeline is only busy while scanning
  a_scan_confined: assert property (@(posedge clk) disable iff (!rst_n)
    p2_valid_r |-> (state_r == S_SCAN))
    else $error("scan element outside of scan");

  // an accepted transaction leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start work");

  // a successful hit never reports a zero count
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[5] && (out_tdata[16:15] == ST_OK)) |->
      (out_tdata[14:7] != 8'd0))
    else $error("hit reported with zero references");

  // order writes in the move state only follow the release check or the walk
  a_move_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE && order_we) |-> $past(state_r == S_REL_CHK || state_r == S_MOVE))
    else $error("recency write outside move walk");

endmodule
